// ----- hw/rtl/sls_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and functions of the log sweep sine generator.
// No dependencies; used by the sine table, the top level and the testbench.

package sls_pkg;

	// field and register widths
	localparam int STEP_W      = 32;
	localparam int LEN_W       = 24;
	localparam int SINE_W      = 16;
	localparam int SAMPLE_W    = 14;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;

	// gain arithmetic: Q0.24 unity and the shared serial multiplier shape
	localparam int GAIN_W = LEN_W + 1;
	localparam logic [GAIN_W-1:0] Q24_ONE = GAIN_W'(25'h100_0000);
	localparam int MUL_A_W = 30;
	localparam int MUL_B_W = GAIN_W;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// angles in Q2.30 for the sine table
	localparam logic [63:0] PI_Q30      = 64'd3373259426;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

	// Taylor series divisors (2n)(2n+1) for n = 1..5
	localparam logic [63:0] SERIES_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_STEP       = 3'd0,
		REG_GROWTH_FACTOR   = 3'd1,
		REG_SWEEP_LENGTH    = 3'd2,
		REG_FADE_IN_LENGTH  = 3'd3,
		REG_FADE_IN_RECIP   = 3'd4,
		REG_FADE_OUT_LENGTH = 3'd5,
		REG_FADE_OUT_RECIP  = 3'd6
	} cfg_reg_t;

	// sample sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_GAIN,
		ST_GPROD,
		ST_AMP
	} state_t;

	// sine of a Q2.30 angle in Q1.15, folded onto the first quarter
	function automatic logic signed [SINE_W-1:0] sine_from_x(input logic [63:0] x_in);
		logic [63:0]        x;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        q;
		logic               neg;
		x   = x_in;
		neg = 1'b0;
		if (x > PI_Q30) begin
			x   = x - PI_Q30;
			neg = 1'b1;
		end
		if (x > HALF_PI_Q30) begin
			x = PI_Q30 - x;
		end
		term = x;
		sum  = signed'(x);
		for (int n = 0; n < 5; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / SERIES_DIV[n];
			if (n % 2 == 0) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		q = 64'(sum + 64'sd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return neg ? SINE_W'(16'd0 - q[15:0]) : q[SINE_W-1:0];
	endfunction

	// clamp a Q0.24 gain product to unity
	function automatic logic [GAIN_W-1:0] sat_one(input logic [MUL_P_W-1:0] p);
		logic over;
		over = (p[MUL_P_W-1:GAIN_W] != '0) || (p[GAIN_W-1] && (p[GAIN_W-2:0] != '0));
		return over ? Q24_ONE : p[GAIN_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/sls_smul.sv -----
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: one bit of the b operand per cycle.
// Stand-alone; instantiated by log_sweep_sine_generator.

module sls_smul #(
	parameter int A_W = 30,
	parameter int B_W = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic [A_W+B_W-1:0] prod,
	output logic               rdy
);

	localparam int P_W   = A_W + B_W;
	localparam int CNT_W = $clog2(B_W + 1);

	logic [A_W-1:0]   a_q;
	logic [P_W-1:0]   p_q;
	logic [CNT_W-1:0] cnt_q;
	logic [A_W:0]     sum;

	// add the multiplicand when the current multiplier bit is set
	assign sum = {1'b0, p_q[P_W-1:B_W]} + (p_q[0] ? {1'b0, a_q} : '0);

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(B_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// product register shifts right, upper half accumulates
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{A_W{1'b0}}, b};
		end else if (cnt_q != '0) begin
			p_q <= {sum, p_q[B_W-1:1]};
		end
	end

	assign prod = p_q;
	assign rdy  = (cnt_q == '0);

endmodule

// ----- hw/rtl/sls_sine_rom.sv -----
`timescale 1ns / 1ps
// Sine table built at elaboration, read through banks in two registered stages.
// Depends on sls_pkg for the angle constants and the sine function.

module sls_sine_rom #(
	parameter int DEPTH = 1024
) (
	input  logic                             clk,
	input  logic [$clog2(DEPTH)-1:0]         addr,
	output logic signed [sls_pkg::SINE_W-1:0] data
);

	localparam int AW      = $clog2(DEPTH);
	localparam int BANK_N  = (DEPTH > 256) ? 256 : DEPTH;
	localparam int BANKS   = DEPTH / BANK_N;
	localparam int BANK_AW = $clog2(BANK_N);

	logic signed [sls_pkg::SINE_W-1:0] table_c [BANKS][BANK_N];
	logic signed [sls_pkg::SINE_W-1:0] bank_s1 [BANKS];
	logic signed [sls_pkg::SINE_W-1:0] data_s2;

	// constant entries, angle k * 2pi / depth in Q2.30
	for (genvar k = 0; k < DEPTH; k++) begin : g_entry
		localparam logic [63:0] XK = (64'(k) * sls_pkg::TWO_PI_Q30) / 64'(DEPTH);
		assign table_c[k / BANK_N][k % BANK_N] = sls_pkg::sine_from_x(XK);
	end

	// first stage: one entry out of every bank
	always_ff @(posedge clk) begin
		for (int b = 0; b < BANKS; b++) begin
			bank_s1[b] <= table_c[b][addr[BANK_AW-1:0]];
		end
	end

	// second stage: pick the bank
	if (BANKS == 1) begin : g_one_bank
		always_ff @(posedge clk) begin
			data_s2 <= bank_s1[0];
		end
	end else begin : g_banks
		logic [AW-BANK_AW-1:0] hi_s1;
		always_ff @(posedge clk) begin
			hi_s1   <= addr[AW-1:BANK_AW];
			data_s2 <= bank_s1[hi_s1];
		end
	end

	assign data = data_s2;

endmodule

// ----- hw/rtl/log_sweep_sine_generator.sv -----
`timescale 1ns / 1ps
// Top level of the exponential sine-sweep source: registers, sequencer, output stage.
// Depends on sls_pkg, sls_smul and sls_sine_rom.
//
//  channel   | signals                           | carries
//  ----------+-----------------------------------+------------------------------------
//  s_        | s_tvalid s_tready s_tdata         | sample tick, restart in bit 0
//  m_        | m_tvalid m_tready m_tdata m_tlast | pcm sample in bits 13:0, last flag
//  cfg_      | cfg_we cfg_index cfg_data         | register writes, index 0..6
//
// A sample tick is accepted in the idle state and is followed by the setup state and three
// passes of the bit-serial multiplier (fade-in gain, gain product, amplitude); fade-out gain
// and step growth run beside them. No new tick is taken before the sample is in the output
// register; an idle tick is taken without a sample and leaves the sequencer idle.
// A full output register that is not taken holds the finished sample back.
// Reset is asynchronous; the sine table is constant, SINE_TABLE_DEPTH a power of two.

module log_sweep_sine_generator #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int INDEX_BITS       = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input ticks
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [sls_pkg::IN_TDATA_W-1:0]     s_tdata,  // [0] restart, [7:1] zero
	// output samples
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [sls_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [13:0] sample, [15:14] zero
	output logic                               m_tlast,
	// configuration
	input  logic                               cfg_we,
	input  logic [sls_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sls_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW    = $clog2(SINE_TABLE_DEPTH);
	localparam int LEN_W = sls_pkg::LEN_W;
	localparam int CW    = ((INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W) + 1;
	localparam int SW    = sls_pkg::STEP_W;
	localparam int GW    = sls_pkg::GAIN_W;
	localparam int MA_W  = sls_pkg::MUL_A_W;
	localparam int MB_W  = sls_pkg::MUL_B_W;
	localparam int MP_W  = sls_pkg::MUL_P_W;
	localparam int SMP_W = sls_pkg::SAMPLE_W;

	// configuration registers
	logic [SW-1:0]    base_step_q;
	logic [SW-1:0]    growth_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] fi_len_q;
	logic [LEN_W-1:0] fi_recip_q;
	logic [LEN_W-1:0] fo_len_q;
	logic [LEN_W-1:0] fo_recip_q;

	// sweep state
	logic [SW-1:0]         acc_q;
	logic [SW-1:0]         step_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic                  run_q;
	sls_pkg::state_t       state_q;
	sls_pkg::state_t       state_d;

	// output register
	logic             out_vld_q;
	logic [SMP_W-1:0] out_sample_q;
	logic             out_last_q;

	// sequencer controls
	logic            accept;
	logic            restart;
	logic            commit;
	logic            start_a;
	logic            start_o;
	logic            start_s;
	logic [MA_W-1:0] a_a;
	logic [MB_W-1:0] b_a;

	// multiplier results
	logic [MP_W-1:0]          prod_a;
	logic [2*LEN_W-1:0]       prod_o;
	logic [2*SW-1:0]          prod_s;
	logic                     rdy_a;
	logic                     rdy_o;
	logic                     rdy_s;

	// index arithmetic
	logic [CW-1:0]    idx_ext;
	logic [CW-1:0]    len_ext;
	logic             fi_act;
	logic             fo_act;
	logic             len_gt;
	logic [LEN_W-1:0] fo_diff;
	logic             last_c;
	logic [GW-1:0]    gi;
	logic [GW-1:0]    go;

	// sine and amplitude
	logic signed [sls_pkg::SINE_W-1:0] rom_data;
	logic [14:0]                       mag15;
	logic [MA_W-1:0]                   m30;
	logic [SMP_W-1:0]                  mag_out;
	logic [SMP_W-1:0]                  sample_c;
	logic [SW-1:0]                     grown;

	assign restart = s_tdata[0];
	assign accept  = s_tvalid && s_tready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_step_q <= '0;
			growth_q    <= SW'(32'h4000_0000);
			len_q       <= LEN_W'(1);
			fi_len_q    <= '0;
			fi_recip_q  <= '0;
			fo_len_q    <= '0;
			fo_recip_q  <= '0;
		end else if (cfg_we) begin
			unique case (sls_pkg::cfg_reg_t'(cfg_index))
				sls_pkg::REG_BASE_STEP:       base_step_q <= cfg_data[SW-1:0];
				sls_pkg::REG_GROWTH_FACTOR:   growth_q    <= cfg_data[SW-1:0];
				sls_pkg::REG_SWEEP_LENGTH:    len_q       <= cfg_data[LEN_W-1:0];
				sls_pkg::REG_FADE_IN_LENGTH:  fi_len_q    <= cfg_data[LEN_W-1:0];
				sls_pkg::REG_FADE_IN_RECIP:   fi_recip_q  <= cfg_data[LEN_W-1:0];
				sls_pkg::REG_FADE_OUT_LENGTH: fo_len_q    <= cfg_data[LEN_W-1:0];
				sls_pkg::REG_FADE_OUT_RECIP:  fo_recip_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// fade windows and last-sample test on the current index
	assign idx_ext = CW'(idx_q);
	assign len_ext = CW'(len_q);
	assign fi_act  = idx_ext < CW'(fi_len_q);
	assign fo_act  = (idx_ext + CW'(fo_len_q)) > len_ext;
	assign len_gt  = len_ext > idx_ext;
	assign fo_diff = len_gt ? LEN_W'(len_ext - idx_ext) : '0;
	assign last_c  = (idx_ext + CW'(1)) >= len_ext;

	// saturated gains from the first multiplier pass
	assign gi = fi_act ? sls_pkg::sat_one(prod_a) : sls_pkg::Q24_ONE;
	assign go = fo_act ? sls_pkg::sat_one(MP_W'(prod_o)) : sls_pkg::Q24_ONE;

	// sine magnitude times 32767, and the signed sample
	assign mag15    = rom_data[15] ? 15'(16'sd0 - rom_data) : rom_data[14:0];
	assign m30      = {mag15, 15'd0} - {15'd0, mag15};
	assign mag_out  = prod_a[MP_W-1:MP_W-SMP_W];
	assign sample_c = rom_data[15] ? (SMP_W'(0) - mag_out) : mag_out;

	// grown step, saturated to 32 bits
	assign grown = (prod_s[2*SW-1:2*SW-2] != 2'b00) ? '1 : prod_s[2*SW-3:SW-2];

	// sequencer: next state and unit controls
	always_comb begin
		state_d = state_q;
		start_a = 1'b0;
		start_o = 1'b0;
		start_s = 1'b0;
		commit  = 1'b0;
		a_a     = '0;
		b_a     = '0;
		unique case (state_q)
			sls_pkg::ST_IDLE: begin
				if (s_tvalid && (restart || run_q)) begin
					state_d = sls_pkg::ST_SETUP;
				end
			end
			sls_pkg::ST_SETUP: begin
				start_a = 1'b1;
				start_o = 1'b1;
				start_s = 1'b1;
				a_a     = MA_W'(fi_recip_q);
				b_a     = MB_W'(idx_ext[LEN_W-1:0]);
				state_d = sls_pkg::ST_GAIN;
			end
			sls_pkg::ST_GAIN: begin
				if (rdy_a && rdy_o) begin
					start_a = 1'b1;
					a_a     = MA_W'(gi);
					b_a     = go;
					state_d = sls_pkg::ST_GPROD;
				end
			end
			sls_pkg::ST_GPROD: begin
				if (rdy_a) begin
					start_a = 1'b1;
					a_a     = m30;
					b_a     = prod_a[LEN_W+GW-1:LEN_W];
					state_d = sls_pkg::ST_AMP;
				end
			end
			sls_pkg::ST_AMP: begin
				if (rdy_a && rdy_s && (!out_vld_q || m_tready)) begin
					commit  = 1'b1;
					state_d = sls_pkg::ST_IDLE;
				end
			end
			default: state_d = sls_pkg::ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sls_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sweep state: restart reloads, a sample loaded into the output register advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			step_q <= '0;
			idx_q  <= '0;
			run_q  <= 1'b0;
		end else if (accept && restart) begin
			acc_q  <= '0;
			step_q <= base_step_q;
			idx_q  <= '0;
			run_q  <= 1'b1;
		end else if (commit) begin
			acc_q  <= acc_q + step_q;
			step_q <= grown;
			idx_q  <= idx_q + 1'b1;
			if (last_c) begin
				run_q <= 1'b0;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (commit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (commit) begin
			out_sample_q <= sample_c;
			out_last_q   <= last_c;
		end
	end

	// gain and amplitude multiplier
	sls_smul #(
		.A_W (MA_W),
		.B_W (MB_W)
	) u_mul_amp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_a),
		.a      (a_a),
		.b      (b_a),
		.prod   (prod_a),
		.rdy    (rdy_a)
	);

	// fade-out gain multiplier
	sls_smul #(
		.A_W (LEN_W),
		.B_W (LEN_W)
	) u_mul_fade (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_o),
		.a      (fo_recip_q),
		.b      (fo_diff),
		.prod   (prod_o),
		.rdy    (rdy_o)
	);

	// step growth multiplier
	sls_smul #(
		.A_W (SW),
		.B_W (SW)
	) u_mul_step (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_s),
		.a      (step_q),
		.b      (growth_q),
		.prod   (prod_s),
		.rdy    (rdy_s)
	);

	// sine table addressed by the top phase bits
	sls_sine_rom #(
		.DEPTH (SINE_TABLE_DEPTH)
	) u_rom (
		.clk  (clk),
		.addr (acc_q[SW-1 -: AW]),
		.data (rom_data)
	);

	assign s_tready = (state_q == sls_pkg::ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(sls_pkg::OUT_TDATA_W - SMP_W){1'b0}}, out_sample_q};
	assign m_tlast  = out_last_q;

endmodule

// ----- tb/tb_log_sweep_sine_generator.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of log_sweep_sine_generator: a directed table of ticks and register
// writes, then random sweeps under several idling patterns. Depends on sls_pkg and the RTL.

module tb_log_sweep_sine_generator;

	localparam int HALF_PERIOD       = 6;
	localparam int RESET_CYCLES      = 7;
	localparam int TAIL_CYCLES       = 120;
	localparam int PHASES            = 16;
	localparam int SAMPLES_PER_PHASE = 50;
	localparam int MAX_REPORTS       = 10;
	localparam int LUT_DEPTH         = 1024;
	localparam int LUT_BITS          = 10;
	localparam int PLAN_ROWS         = 38;
	localparam int SMP_W             = sls_pkg::SAMPLE_W;
	localparam int OUT_W             = sls_pkg::OUT_TDATA_W;
	localparam logic [63:0] UNITY_Q24 = 64'd16777216;
	localparam logic [63:0] ANGLE_PI  = 64'd3373259426;
	localparam logic [63:0] ANGLE_2PI = 64'd6746518852;

	typedef logic signed [SMP_W-1:0] pcm_t;

	typedef struct packed {
		pcm_t pcm;
		logic tail;
	} sample_rec_t;

	typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} row_check_t;

	typedef struct packed {
		row_kind_t         kind;
		sls_pkg::cfg_reg_t reg_sel;
		logic [31:0]       value;
		logic              restart;
		row_check_t        chk;
		pcm_t              pcm;
		logic              tail;
	} plan_row_t;

	// idling patterns: none, sender idle, receiver stalling, both a little
	localparam int SEND_IDLE [4] = '{0, 84, 0, 6};
	localparam int RECV_STALL [4] = '{0, 0, 84, 6};

	// directed table; rows with CHK_GIVEN carry the sample that is expected
	localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
		// idle tick after reset, then a one-sample sweep from phase zero
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b1, CHK_GIVEN, pcm_t'(0), 1'b1},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		// quarter-turn steps hit zero, positive peak, zero, negative peak
		'{ROW_WRITE, sls_pkg::REG_BASE_STEP, 32'h4000_0000, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_WRITE, sls_pkg::REG_SWEEP_LENGTH, 32'h4, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b1, CHK_GIVEN, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b0, CHK_GIVEN, pcm_t'(8191), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b0, CHK_GIVEN, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b0, CHK_GIVEN, pcm_t'(-8191), 1'b1},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		// short sweep with fade-in, fade-out and a growing step
		'{ROW_WRITE, sls_pkg::REG_FADE_IN_LENGTH, 32'h3, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_WRITE, sls_pkg::REG_FADE_IN_RECIP, 32'h55_5555, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_WRITE, sls_pkg::REG_FADE_OUT_LENGTH, 32'h3, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_WRITE, sls_pkg::REG_FADE_OUT_RECIP, 32'h55_5555, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_WRITE, sls_pkg::REG_BASE_STEP, 32'h0100_0000, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_WRITE, sls_pkg::REG_GROWTH_FACTOR, 32'h4800_0000, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_WRITE, sls_pkg::REG_SWEEP_LENGTH, 32'h6, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b1, CHK_MODEL, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b0, CHK_MODEL, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b0, CHK_MODEL, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b0, CHK_MODEL, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b0, CHK_MODEL, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b0, CHK_MODEL, pcm_t'(0), 1'b0},
		// saturating fade-in gain, step overflow, restart in the middle of a sweep
		'{ROW_WRITE, sls_pkg::REG_FADE_IN_RECIP, 32'hFF_FFFF, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_WRITE, sls_pkg::REG_FADE_OUT_RECIP, 32'hFF_FFFF, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_WRITE, sls_pkg::REG_BASE_STEP, 32'hFFFF_FFFF, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_WRITE, sls_pkg::REG_GROWTH_FACTOR, 32'hFFFF_FFFF, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_WRITE, sls_pkg::REG_SWEEP_LENGTH, 32'hFF_FFFF, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b1, CHK_MODEL, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b0, CHK_MODEL, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b1, CHK_MODEL, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b0, CHK_MODEL, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b0, CHK_MODEL, pcm_t'(0), 1'b0},
		// length shrunk below the index: flagged last with zero fade-out gain
		'{ROW_WRITE, sls_pkg::REG_SWEEP_LENGTH, 32'h1, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b0, CHK_GIVEN, pcm_t'(0), 1'b1},
		// zero length behaves as one; fade-in gain is zero at index zero
		'{ROW_WRITE, sls_pkg::REG_SWEEP_LENGTH, 32'h0, 1'b0, CHK_NONE, pcm_t'(0), 1'b0},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b1, CHK_GIVEN, pcm_t'(0), 1'b1},
		'{ROW_TICK,  sls_pkg::REG_BASE_STEP, 32'h0, 1'b0, CHK_NONE, pcm_t'(0), 1'b0}
	};

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [sls_pkg::IN_TDATA_W-1:0]   s_tdata;   // [0] restart, [7:1] zero
	logic                             m_tvalid;
	logic                             m_tready;
	logic [OUT_W-1:0]                 m_tdata;   // [13:0] sample, [15:14] zero
	logic                             m_tlast;
	logic                             cfg_we;
	logic [sls_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [sls_pkg::CFG_DATA_W-1:0]   cfg_data;

	// local copy of the registers
	logic [31:0] cfg_base;
	logic [31:0] cfg_growth;
	logic [23:0] cfg_len;
	logic [23:0] cfg_fin_len;
	logic [23:0] cfg_fin_rcp;
	logic [23:0] cfg_fout_len;
	logic [23:0] cfg_fout_rcp;

	// sweep state of the predictor
	logic [31:0] phase_word;
	logic [31:0] step_word;
	logic [23:0] sweep_pos;
	logic        sweeping;
	int          sine_lut [LUT_DEPTH];

	sample_rec_t awaited_samples [$];
	int          fault_count = 0;
	int          send_idle_pct = 0;
	int          ready_stall_pct = 0;

	log_sweep_sine_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// sine of table entry k in Q1.15 by a Q2.30 series on the first quarter
	function automatic int sine_q15(input int k);
		logic [63:0]        ang;
		logic [63:0]        t;
		logic signed [63:0] acc;
		logic [63:0]        q;
		logic               neg;
		ang = (64'(k) * ANGLE_2PI) / 64'(LUT_DEPTH);
		neg = 1'b0;
		if (ang > ANGLE_PI) begin
			ang = ang - ANGLE_PI;
			neg = 1'b1;
		end
		if (ang > ANGLE_PI / 2) begin
			ang = ANGLE_PI - ang;
		end
		t   = ang;
		acc = signed'(ang);
		// terms x^3 to x^11, alternating in sign
		for (int n = 1; n <= 5; n++) begin
			t = (t * ang) >> 30;
			t = (t * ang) >> 30;
			t = t / 64'((2 * n) * (2 * n + 1));
			acc = (n % 2 == 1) ? acc - signed'(t) : acc + signed'(t);
		end
		if (acc < 0) begin
			acc = 0;
		end
		q = (64'(acc) + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return neg ? -int'(q) : int'(q);
	endfunction

	// one tick of the sweep: the sample it yields, if any, and the state update
	function automatic void step_sweep(input logic restart, output logic produced,
			output sample_rec_t rec);
		logic [63:0]        pos;
		logic [63:0]        len;
		logic [63:0]        gin;
		logic [63:0]        gout;
		logic [63:0]        gain;
		logic [63:0]        mag;
		logic [63:0]        grown;
		logic signed [63:0] val;
		int                 s;
		rec      = '0;
		produced = 1'b0;
		if (restart) begin
			phase_word = '0;
			step_word  = cfg_base;
			sweep_pos  = '0;
			sweeping   = 1'b1;
		end
		if (!sweeping) begin
			return;
		end
		pos = 64'(sweep_pos);
		len = 64'(cfg_len);
		// fade gains in Q0.24, clamped to unity
		gin = UNITY_Q24;
		if (pos < 64'(cfg_fin_len)) begin
			gin = pos * 64'(cfg_fin_rcp);
			if (gin > UNITY_Q24) begin
				gin = UNITY_Q24;
			end
		end
		gout = UNITY_Q24;
		if (pos + 64'(cfg_fout_len) > len) begin
			gout = (len > pos) ? (len - pos) * 64'(cfg_fout_rcp) : 64'd0;
			if (gout > UNITY_Q24) begin
				gout = UNITY_Q24;
			end
		end
		gain = (gin * gout) >> 24;
		// quarter amplitude, truncated toward zero
		s   = sine_lut[phase_word[31 -: LUT_BITS]];
		mag = 64'((s < 0) ? -s : s);
		mag = (mag * 64'd32767 * gain) >> 41;
		val = (s < 0) ? -signed'(mag) : signed'(mag);
		rec.pcm  = val[SMP_W-1:0];
		rec.tail = (pos + 64'd1 >= len);
		produced = 1'b1;
		// advance phase, grow the step with saturation
		phase_word = phase_word + step_word;
		grown      = (64'(step_word) * 64'(cfg_growth)) >> 30;
		step_word  = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
		sweep_pos  = sweep_pos + 1'b1;
		if (rec.tail) begin
			sweeping = 1'b0;
		end
	endfunction

	// random fade length, mostly within the sweep
	function automatic logic [23:0] pick_fade_len(input logic [23:0] len);
		int lim;
		lim = (len > 24'd40) ? 40 : ((len == 0) ? 1 : int'(len));
		case ($urandom_range(0, 4))
			0:       return 24'h0;
			1:       return 24'hFF_FFFF;
			default: return 24'($urandom_range(0, lim));
		endcase
	endfunction

	// random reciprocal, usually close to one over the fade length
	function automatic logic [23:0] pick_recip(input logic [23:0] fade_len);
		case ($urandom_range(0, 5))
			0:       return 24'h0;
			1:       return 24'hFF_FFFF;
			2:       return 24'($urandom());
			default: return (fade_len < 24'd2) ? 24'hFF_FFFF : 24'(32'h0100_0000 / fade_len);
		endcase
	endfunction

	// register write, mirrored into the local copy
	task automatic write_reg(input sls_pkg::cfg_reg_t sel, input logic [31:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= value;
		@(posedge clk);
		case (sel)
			sls_pkg::REG_BASE_STEP:       cfg_base     = value;
			sls_pkg::REG_GROWTH_FACTOR:   cfg_growth   = value;
			sls_pkg::REG_SWEEP_LENGTH:    cfg_len      = value[23:0];
			sls_pkg::REG_FADE_IN_LENGTH:  cfg_fin_len  = value[23:0];
			sls_pkg::REG_FADE_IN_RECIP:   cfg_fin_rcp  = value[23:0];
			sls_pkg::REG_FADE_OUT_LENGTH: cfg_fout_len = value[23:0];
			sls_pkg::REG_FADE_OUT_RECIP:  cfg_fout_rcp = value[23:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// stop sending, wait for every awaited sample, then let the sequencer go quiet
	task automatic settle_block();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// one tick transaction on the input side, with a random gap before it
	task automatic push_tick(input logic restart, input row_check_t chk,
			input pcm_t given_pcm, input logic given_tail, output logic produced);
		int          gap;
		sample_rec_t rec;
		gap = 0;
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct && gap < 200) begin
			gap++;
		end
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sls_pkg::IN_TDATA_W'(restart);
		do begin
			@(posedge clk);
		end while (!s_tready);
		step_sweep(restart, produced, rec);
		case (chk)
			CHK_MODEL: begin
				if (produced) begin
					awaited_samples.push_back(rec);
				end
			end
			CHK_GIVEN: begin
				rec.pcm  = given_pcm;
				rec.tail = given_tail;
				awaited_samples.push_back(rec);
			end
			default: ;
		endcase
	endtask

	// new settings for a phase, extremes among them; junk above bit 23 of short registers
	task automatic program_random_settings();
		logic [31:0] base;
		logic [31:0] growth;
		logic [23:0] len;
		logic [23:0] fin;
		logic [23:0] fout;
		case ($urandom_range(0, 3))
			0:       base = 32'h0;
			1:       base = 32'hFFFF_FFFF;
			2:       base = $urandom_range(0, 32'h0200_0000);
			default: base = $urandom();
		endcase
		case ($urandom_range(0, 5))
			0:       growth = 32'h0;
			1:       growth = 32'hFFFF_FFFF;
			2:       growth = 32'h4000_0000;
			3, 4:    growth = 32'h4000_0000 + $urandom_range(0, 32'h0100_0000);
			default: growth = $urandom();
		endcase
		case ($urandom_range(0, 9))
			0:       len = 24'h0;
			1:       len = 24'h1;
			2:       len = 24'hFF_FFFF;
			default: len = 24'($urandom_range(2, 40));
		endcase
		fin  = pick_fade_len(len);
		fout = pick_fade_len(len);
		write_reg(sls_pkg::REG_BASE_STEP, base);
		write_reg(sls_pkg::REG_GROWTH_FACTOR, growth);
		write_reg(sls_pkg::REG_SWEEP_LENGTH, {8'($urandom()), len});
		write_reg(sls_pkg::REG_FADE_IN_LENGTH, {8'($urandom()), fin});
		write_reg(sls_pkg::REG_FADE_IN_RECIP, {8'($urandom()), pick_recip(fin)});
		write_reg(sls_pkg::REG_FADE_OUT_LENGTH, {8'($urandom()), fout});
		write_reg(sls_pkg::REG_FADE_OUT_RECIP, {8'($urandom()), pick_recip(fout)});
	endtask

	// receiver side stalls
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
	end

	// compare each output transaction with the oldest awaited sample
	always @(posedge clk) begin
		sample_rec_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_samples.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS) begin
					$display("unexpected sample %0d last %0b at %0t",
						$signed(m_tdata[SMP_W-1:0]), m_tlast, $realtime);
				end
			end else begin
				want = awaited_samples.pop_front();
				if (m_tdata !== {{(OUT_W-SMP_W){1'b0}}, want.pcm} ||
						m_tlast !== want.tail) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS) begin
						$display({"sample mismatch at %0t: expected %0d last %0b, ",
							"got %0d (tdata %h) last %0b"},
							$realtime, want.pcm, want.tail,
							$signed(m_tdata[SMP_W-1:0]), m_tdata, m_tlast);
					end
				end
			end
		end
	end

	// run limit
	initial begin
		#20_000_000;
		$display("tb_log_sweep_sine_generator NOT OK");
		$finish;
	end

	// stimulus
	initial begin
		plan_row_t row;
		logic      got;
		logic      go_restart;
		int        produced_count;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = sls_pkg::REG_BASE_STEP;
		cfg_data  = '0;
		// register and sweep state after reset
		cfg_base     = 32'h0;
		cfg_growth   = 32'h4000_0000;
		cfg_len      = 24'h1;
		cfg_fin_len  = 24'h0;
		cfg_fin_rcp  = 24'h0;
		cfg_fout_len = 24'h0;
		cfg_fout_rcp = 24'h0;
		phase_word   = '0;
		step_word    = '0;
		sweep_pos    = '0;
		sweeping     = 1'b0;
		for (int k = 0; k < LUT_DEPTH; k++) begin
			sine_lut[k] = sine_q15(k);
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table, no idling
		for (int r = 0; r < PLAN_ROWS; r++) begin
			row = DIRECTED_PLAN[r];
			if (row.kind == ROW_WRITE) begin
				settle_block();
				write_reg(row.reg_sel, row.value);
			end else begin
				push_tick(row.restart, row.chk, row.pcm, row.tail, got);
			end
		end

		// random sweeps, new settings and idling pattern per phase
		for (int p = 0; p < PHASES; p++) begin
			settle_block();
			send_idle_pct   = SEND_IDLE[p % 4];
			ready_stall_pct = RECV_STALL[p % 4];
			program_random_settings();
			produced_count = 0;
			while (produced_count < SAMPLES_PER_PHASE) begin
				// mostly whole sweeps; now and then a restart mid-sweep or a stray idle tick
				go_restart = sweeping ? ($urandom_range(0, 99) < 3)
					: ($urandom_range(0, 99) < 85);
				push_tick(go_restart, CHK_MODEL, '0, 1'b0, got);
				if (got) begin
					produced_count++;
				end
			end
		end

		settle_block();
		if (fault_count == 0) begin
			$display("tb_log_sweep_sine_generator OK");
		end else begin
			$display("tb_log_sweep_sine_generator NOT OK");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/sls_pkg.sv
hw/rtl/sls_smul.sv
hw/rtl/sls_sine_rom.sv
hw/rtl/log_sweep_sine_generator.sv
tb/tb_log_sweep_sine_generator.sv
